// ===== hw/rtl/smd_pkg.sv =====
// Shared types, constants and helpers of the stream message deframer.
// No dependencies; imported by every module of the block.
package smd_pkg;

  localparam int unsigned MAX_SEP_DEFAULT = 8;
  localparam int unsigned HEADER_BYTES    = 5;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned SEP_STR_W       = 64;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned HDR_CNT_W       = 3;
  localparam int unsigned LEN_W           = 32;

  typedef enum logic [1:0] {
    MODE_PASS       = 2'd0,
    MODE_BYTE_SEP   = 2'd1,
    MODE_STR_SEP    = 2'd2,
    MODE_LEN_PREFIX = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 8'd0,
    REG_SEP_BYTE = 8'd1,
    REG_SEP_STR  = 8'd2,
    REG_SEP_LEN  = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    mode_e                mode;
    logic [7:0]           sep_byte;
    logic [SEP_STR_W-1:0] sep_str;
    logic [CNT_W-1:0]     sep_len;
  } cfg_t;

  // Flush flush_cnt separator bytes from index 0, then the optional tail result.
  typedef struct packed {
    logic [CNT_W-1:0] flush_cnt;
    logic             has_tail;
    logic [7:0]       tail_byte;
    logic             tail_valid;
    logic             tail_end;
  } cmd_t;

  function automatic logic [7:0] sep_at(logic [SEP_STR_W-1:0] s, logic [CNT_W-1:0] i);
    return s[i[2:0]*8 +: 8];
  endfunction

endpackage

// ===== hw/rtl/smd_front.sv =====
// Front end: accepts stream bytes, tracks separator and header state,
// and issues at most one command per byte. Depends on smd_pkg.
module smd_front import smd_pkg::*; #(
  parameter int unsigned MAX_SEPARATOR_BYTES = MAX_SEP_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       chunk_end_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [CNT_W-1:0]     match_q, match_d;
  logic [HDR_CNT_W-1:0] hdr_q, hdr_d;
  logic                 big_q, big_d;
  logic [LEN_W-1:0]     acc_q, acc_d;
  logic [LEN_W-1:0]     rem_q, rem_d;

  logic [CNT_W-1:0]     len_eff;
  logic [CNT_W-1:0]     mc_eff;
  logic [CNT_W-1:0]     mc_inc;
  logic [HDR_CNT_W-1:0] hdr_m1;
  logic [HDR_CNT_W-1:0] hdr_inc;
  logic [LEN_W-1:0]     acc_n;
  cmd_t                 cmd;

  assign len_eff = (cfg_i.sep_len > CNT_W'(MAX_SEPARATOR_BYTES)) ?
                   CNT_W'(MAX_SEPARATOR_BYTES) : cfg_i.sep_len;
  assign mc_eff  = (match_q >= len_eff) ? '0 : match_q;
  assign mc_inc  = mc_eff + 1'b1;
  assign hdr_m1  = hdr_q - 1'b1;
  assign hdr_inc = hdr_q + 1'b1;
  assign acc_n   = big_q ? {acc_q[LEN_W-9:0], data_byte_i}
                         : acc_q | ({24'b0, data_byte_i} << {hdr_m1[1:0], 3'b000});

  always_comb begin
    match_d = match_q;
    hdr_d   = hdr_q;
    big_d   = big_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    cmd     = '{flush_cnt: '0, has_tail: 1'b0, tail_byte: '0,
                tail_valid: 1'b0, tail_end: 1'b0};
    case (cfg_i.mode)
      MODE_BYTE_SEP: begin
        cmd.has_tail   = 1'b1;
        cmd.tail_byte  = data_byte_i;
        cmd.tail_valid = 1'b1;
        cmd.tail_end   = (data_byte_i == cfg_i.sep_byte);
      end
      MODE_LEN_PREFIX: begin
        if (rem_q != '0) begin
          rem_d          = rem_q - 1'b1;
          cmd.has_tail   = 1'b1;
          cmd.tail_byte  = data_byte_i;
          cmd.tail_valid = 1'b1;
          cmd.tail_end   = (rem_q == LEN_W'(1));
        end else if (hdr_q == '0) begin
          big_d = (data_byte_i != 8'h00);
          acc_d = '0;
          hdr_d = HDR_CNT_W'(1);
        end else begin
          acc_d = acc_n;
          hdr_d = hdr_inc;
          if (hdr_inc >= HDR_CNT_W'(HEADER_BYTES)) begin
            hdr_d = '0;
            if (acc_n == '0) begin
              cmd.has_tail = 1'b1;
              cmd.tail_end = 1'b1;
            end else begin
              rem_d = acc_n;
            end
          end
        end
      end
      MODE_STR_SEP: begin
        if (len_eff == '0) begin
          cmd.has_tail   = 1'b1;
          cmd.tail_byte  = data_byte_i;
          cmd.tail_valid = 1'b1;
          cmd.tail_end   = chunk_end_i;
        end else if (data_byte_i == sep_at(cfg_i.sep_str, mc_eff)) begin
          if (mc_inc >= len_eff) begin
            match_d      = '0;
            cmd.has_tail = 1'b1;
            cmd.tail_end = 1'b1;
          end else if (chunk_end_i) begin
            match_d       = '0;
            cmd.flush_cnt = mc_inc;
          end else begin
            match_d = mc_inc;
          end
        end else begin
          cmd.flush_cnt = mc_eff;
          match_d       = '0;
          if (data_byte_i == sep_at(cfg_i.sep_str, '0)) begin
            if (len_eff == CNT_W'(1)) begin
              cmd.has_tail = 1'b1;
              cmd.tail_end = 1'b1;
            end else if (chunk_end_i) begin
              cmd.has_tail   = 1'b1;
              cmd.tail_byte  = data_byte_i;
              cmd.tail_valid = 1'b1;
            end else begin
              match_d = CNT_W'(1);
            end
          end else begin
            cmd.has_tail   = 1'b1;
            cmd.tail_byte  = data_byte_i;
            cmd.tail_valid = 1'b1;
          end
        end
      end
      default: begin
        cmd.has_tail   = 1'b1;
        cmd.tail_byte  = data_byte_i;
        cmd.tail_valid = 1'b1;
        cmd.tail_end   = chunk_end_i;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && (cmd.has_tail || (cmd.flush_cnt != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      hdr_q   <= '0;
      big_q   <= 1'b0;
      acc_q   <= '0;
      rem_q   <= '0;
    end else if (accept_i) begin
      match_q <= match_d;
      hdr_q   <= hdr_d;
      big_q   <= big_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== hw/rtl/smd_queue.sv =====
// Short command queue between front and back end.
// Depends on smd_pkg for the command type and depth.
module smd_queue import smd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? PTR_W'((wr_q + 1'b1) % QUEUE_DEPTH) : wr_q;
    rd_d  = pop_i  ? PTR_W'((rd_q + 1'b1) % QUEUE_DEPTH) : rd_q;
    cnt_d = cnt_q + CNT_QW'(push_i) - CNT_QW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/smd_back.sv =====
// Back end: expands queued commands into results, one per cycle while the
// output is not stalled, into the output register. Depends on smd_pkg.
module smd_back import smd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SEP_STR_W-1:0] sep_str_i,
  input  logic                 empty_i,
  input  cmd_t                 head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 message_end_o
);

  logic [CNT_W-1:0] pos_q, pos_d;
  logic             ovalid_q, ovalid_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             obv_q, obv_d;
  logic             oend_q, oend_d;
  logic             load;
  logic             in_flush;
  logic             last;

  assign load     = !ovalid_q || !out_stall_i;
  assign in_flush = (pos_q < head_i.flush_cnt);
  assign last     = in_flush ? ((pos_q + 1'b1 == head_i.flush_cnt) && !head_i.has_tail)
                             : 1'b1;
  assign pop_o    = load && !empty_i && last;

  always_comb begin
    pos_d    = pos_q;
    ovalid_d = ovalid_q;
    obyte_d  = obyte_q;
    obv_d    = obv_q;
    oend_d   = oend_q;
    if (load) begin
      ovalid_d = !empty_i;
      if (!empty_i) begin
        if (in_flush) begin
          obyte_d = sep_at(sep_str_i, pos_q);
          obv_d   = 1'b1;
          oend_d  = 1'b0;
        end else begin
          obyte_d = head_i.tail_byte;
          obv_d   = head_i.tail_valid;
          oend_d  = head_i.tail_end;
        end
        pos_d = last ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    obv_q   <= obv_d;
    oend_q  <= oend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign out_byte_o    = obyte_q;
  assign byte_valid_o  = obv_q;
  assign message_end_o = oend_q;

endmodule

// ===== hw/rtl/stream_message_deframer_top.sv =====
// Stream message deframer top level: configuration registers, front end,
// command queue and back end. Depends on smd_pkg, smd_front, smd_queue, smd_back.
//
// Takes one stream byte per cycle and splits the stream into messages in one of
// four framing modes (pass-through, byte separator, string separator, length
// prefix). Each accepted byte yields zero to eight results; results leave one per
// cycle from the output register while out_stall_i is low. A four-entry command
// queue between the byte classifier and the result expander absorbs the bursts
// when a partial separator match is flushed; input stalls only when that queue
// is full. Configuration writes are always ready and must be made while the
// block is idle.
module stream_message_deframer_top import smd_pkg::*; #(
  parameter int unsigned MAX_SEPARATOR_BYTES = MAX_SEP_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  chunk_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  byte_valid_o,
  output logic                  message_end_o
);

  cfg_t cfg_q, cfg_d;
  logic accept;
  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t cmd;
  cmd_t head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:     cfg_d.mode     = mode_e'(cfg_data_i[1:0]);
        REG_SEP_BYTE: cfg_d.sep_byte = cfg_data_i[7:0];
        REG_SEP_STR:  cfg_d.sep_str  = cfg_data_i[SEP_STR_W-1:0];
        REG_SEP_LEN:  cfg_d.sep_len  = cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_PASS, sep_byte: '0, sep_str: '0, sep_len: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  smd_front #(
    .MAX_SEPARATOR_BYTES(MAX_SEPARATOR_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .chunk_end_i(chunk_end_i),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  smd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  smd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sep_str_i    (cfg_q.sep_str),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .message_end_o(message_end_o)
  );

endmodule

// ===== hw/rtl/smd_checker.sv =====
// Port-level checks of the stream message deframer, bound to the top level.
// Depends on smd_pkg and stream_message_deframer_top.
module smd_checker import smd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [7:0]            data_byte_i,
  input logic                  chunk_end_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [7:0]            out_byte_o,
  input logic                  byte_valid_o,
  input logic                  message_end_o
);

  logic seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_valid_o) && $stable(message_end_o))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i)
      && $stable(chunk_end_i))
    else $error("stalled input transaction changed");

  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> message_end_o && (out_byte_o == 8'h00))
    else $error("end marker malformed");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("result without any accepted byte");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind stream_message_deframer_top smd_checker u_smd_checker (.*);

// ===== test/stream_message_deframer_top_tb.sv =====
// Self-checking testbench for stream_message_deframer_top: directed and random byte streams
// in all four framing modes, checked against an in-bench predictor of the deframer.
// Depends on smd_pkg and the deframer RTL only.
`timescale 1ns / 100ps

module stream_message_deframer_top_tb;
  import smd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       message_end;
  } result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  chunk_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic                  byte_valid_o;
  logic                  message_end_o;

  // predictor configuration and state
  mode_e       cfg_mode = MODE_PASS;
  logic [7:0]  cfg_sep_byte = '0;
  logic [63:0] cfg_sep_str = '0;
  logic [3:0]  cfg_sep_len = '0;
  logic [3:0]  match_cnt = '0;
  logic [2:0]  hdr_cnt = '0;
  logic        hdr_big_endian = 1'b0;
  logic [31:0] len_acc = '0;
  logic [31:0] payload_left = '0;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  stream_message_deframer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .chunk_end_i   (chunk_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .message_end_o (message_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("stream_message_deframer_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 30);
  end

  function automatic logic [7:0] separator_byte_at(int unsigned i);
    return cfg_sep_str[8 * (i % 8) +: 8];
  endfunction

  function automatic int unsigned separator_span();
    return (cfg_sep_len > MAX_SEP_DEFAULT) ? MAX_SEP_DEFAULT : cfg_sep_len;
  endfunction

  function automatic void queue_result(logic [7:0] b, logic v, logic e);
    result_t r;
    r.out_byte = b;
    r.byte_valid = v;
    r.message_end = e;
    pending_results.push_back(r);
  endfunction

  function automatic void flush_held_separator();
    for (int unsigned i = 0; i < match_cnt; i++) queue_result(separator_byte_at(i), 1'b1, 1'b0);
    match_cnt = '0;
  endfunction

  function automatic void deframe_byte(logic [7:0] b, logic ce);
    int unsigned span;
    span = separator_span();
    if (cfg_mode == MODE_BYTE_SEP) begin
      queue_result(b, 1'b1, b == cfg_sep_byte);
    end else if (cfg_mode == MODE_STR_SEP && span > 0) begin
      if (match_cnt >= span) match_cnt = '0;
      if (b == separator_byte_at(match_cnt)) begin
        match_cnt++;
        if (match_cnt >= span) begin
          match_cnt = '0;
          queue_result(8'h00, 1'b0, 1'b1);
        end
      end else begin
        flush_held_separator();
        if (b == separator_byte_at(0)) begin
          if (span == 1) queue_result(8'h00, 1'b0, 1'b1);
          else match_cnt = 4'd1;
        end else begin
          queue_result(b, 1'b1, 1'b0);
        end
      end
      if (ce && match_cnt > 0) flush_held_separator();
    end else if (cfg_mode == MODE_LEN_PREFIX) begin
      if (payload_left > 0) begin
        payload_left--;
        queue_result(b, 1'b1, payload_left == 0);
      end else if (hdr_cnt == 0) begin
        hdr_big_endian = (b != 8'h00);
        len_acc = '0;
        hdr_cnt = 3'd1;
      end else begin
        if (hdr_big_endian) len_acc = {len_acc[23:0], b};
        else len_acc = len_acc | (32'(b) << (8 * ((hdr_cnt - 1) % 4)));
        hdr_cnt++;
        if (hdr_cnt >= HEADER_BYTES) begin
          hdr_cnt = '0;
          if (len_acc == 0) queue_result(8'h00, 1'b0, 1'b1);
          else payload_left = len_acc;
        end
      end
    end else begin
      queue_result(b, 1'b1, ce);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result byte %h valid %b end %b", $realtime,
                 out_byte_o, byte_valid_o, message_end_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $realtime, want.out_byte, out_byte_o);
          mismatches++;
        end
        if (byte_valid_o !== want.byte_valid) begin
          $display("%0t: byte_valid expected %b actual %b", $realtime, want.byte_valid,
                   byte_valid_o);
          mismatches++;
        end
        if (message_end_o !== want.message_end) begin
          $display("%0t: message_end expected %b actual %b", $realtime, want.message_end,
                   message_end_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ce);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    data_byte_i = b;
    chunk_end_i = ce;
    do @(posedge clk_i); while (in_stall_o);
    deframe_byte(b, ce);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MODE:     cfg_mode = mode_e'(value[1:0]);
      REG_SEP_BYTE: cfg_sep_byte = value[7:0];
      REG_SEP_STR:  cfg_sep_str = value;
      REG_SEP_LEN:  cfg_sep_len = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // content with frequent separator bytes, then a whole or broken separator
  task automatic send_separated(input int unsigned n_content, input bit broken);
    int unsigned span;
    int unsigned cut;
    span = separator_span();
    for (int unsigned i = 0; i < n_content; i++) begin
      if ($urandom_range(99) < 25) send_byte(separator_byte_at($urandom_range(span - 1)),
                                             $urandom_range(9) == 0);
      else send_byte(8'($urandom), $urandom_range(9) == 0);
    end
    cut = broken ? $urandom_range(span - 1) : span;
    for (int unsigned i = 0; i < cut; i++) send_byte(separator_byte_at(i), $urandom_range(19) == 0);
    if (broken) send_byte(8'($urandom), $urandom_range(3) == 0);
  endtask

  task automatic send_length_frame(input logic [31:0] n, input bit big);
    send_byte(big ? 8'($urandom_range(255, 1)) : 8'h00, $urandom_range(1));
    for (int i = 0; i < 4; i++) begin
      send_byte(big ? n[8 * (3 - i) +: 8] : n[8 * i +: 8], $urandom_range(1));
    end
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom), $urandom_range(1));
  endtask

  task automatic test_directed_pass_and_byte();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    write_reg(REG_MODE, 64'(MODE_BYTE_SEP));
    write_reg(REG_SEP_BYTE, 64'hFF);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_directed_string_sep();
    write_reg(REG_MODE, 64'(MODE_STR_SEP));
    write_reg(REG_SEP_LEN, 64'd0);
    send_byte(8'h41, 1'b1);
    write_reg(REG_SEP_STR, 64'h434241);
    write_reg(REG_SEP_LEN, 64'd3);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h41, 1'b1);
    // broken match restarting on the first separator byte
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b0);
    // hold a match across a shorter separator length
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    write_reg(REG_SEP_LEN, 64'd2);
    send_byte(8'h5A, 1'b0);
  endtask

  task automatic test_directed_length_prefix();
    write_reg(REG_MODE, 64'(MODE_LEN_PREFIX));
    send_length_frame(32'd1, 1'b0);
    send_length_frame(32'd0, 1'b1);
  endtask

  task automatic test_random_pass_through();
    write_reg(REG_MODE, 64'(MODE_PASS));
    for (int i = 0; i < 20; i++) send_byte(8'($urandom), $urandom_range(3) == 0);
    write_reg(REG_MODE, 64'(MODE_STR_SEP));
    write_reg(REG_SEP_LEN, 64'd0);
    for (int i = 0; i < 15; i++) send_byte(8'($urandom), $urandom_range(3) == 0);
  endtask

  task automatic test_random_byte_sep();
    logic [7:0] sep;
    steady = 1'b1;
    write_reg(REG_MODE, 64'(MODE_BYTE_SEP));
    for (int s = 0; s < 4; s++) begin
      sep = (s == 0) ? 8'h00 : (s == 1) ? 8'hFF : 8'($urandom);
      write_reg(REG_SEP_BYTE, 64'(sep));
      for (int i = 0; i < 10; i++) begin
        send_byte(($urandom_range(99) < 30) ? sep : 8'($urandom), $urandom_range(1));
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_random_string_sep();
    int unsigned stop;
    logic [63:0] sep;
    write_reg(REG_MODE, 64'(MODE_STR_SEP));
    for (int s = 0; s < 10; s++) begin
      if (s == 7) sep = '1;
      else if (s == 2) sep = '0;
      else if (s % 3 == 1) sep = {8{8'($urandom)}};
      else sep = {$urandom, $urandom};
      write_reg(REG_SEP_STR, sep);
      write_reg(REG_SEP_LEN, (s < 8) ? 64'(s + 1) : (s == 8) ? 64'd12 : 64'd15);
      stop = bytes_sent + 6;
      while (bytes_sent < stop) send_separated($urandom_range(4), $urandom_range(3) == 0);
    end
  endtask

  task automatic test_random_length_prefix();
    int unsigned stop;
    write_reg(REG_MODE, 64'(MODE_LEN_PREFIX));
    stop = bytes_sent + 75;
    while (bytes_sent < stop) begin
      if ($urandom_range(9) == 0) send_length_frame($urandom_range(20), $urandom_range(1));
      else send_length_frame($urandom_range(6), $urandom_range(1));
    end
  endtask

  // leaves a payload count that never runs out, so it comes last for this mode
  task automatic test_length_limit();
    send_byte(8'($urandom_range(255, 1)), $urandom_range(1));
    for (int i = 0; i < 4; i++) send_byte(8'hFF, $urandom_range(1));
    for (int i = 0; i < 6; i++) send_byte(8'($urandom), $urandom_range(1));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_pass_and_byte();
    test_directed_string_sep();
    test_directed_length_prefix();
    test_random_pass_through();
    test_random_byte_sep();
    test_random_string_sep();
    test_random_length_prefix();
    test_length_limit();
    wait_idle();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("stream_message_deframer_top regression: pass");
    end else begin
      $display("stream_message_deframer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== stream_message_deframer_top.f =====
hw/rtl/smd_pkg.sv
hw/rtl/smd_front.sv
hw/rtl/smd_queue.sv
hw/rtl/smd_back.sv
hw/rtl/stream_message_deframer_top.sv
hw/rtl/smd_checker.sv
test/stream_message_deframer_top_tb.sv
